[hw/rtl/zmpoc_pkg.sv]
// ----------------------------------------------------------------------------
// zmpoc_pkg
// Shared types and constants for the ZMP estimator with offset calibration.
// ----------------------------------------------------------------------------
package zmpoc_pkg;

  // Fixed-point format of all forces, torques and ZMP values
  localparam int unsigned DW = 32;
  localparam int unsigned FB = 16;

  // Widths of intermediate values
  localparam int unsigned HW      = 17;           // sensor height
  localparam int unsigned CW      = 16;           // calibration length / count
  localparam int unsigned FOOT_NW = 2 * DW - FB + 2;  // foot numerator
  localparam int unsigned MRG_NW  = 2 * DW + 1;   // combine numerator
  localparam int unsigned MRG_DW  = DW + 1;       // combine divisor
  localparam int unsigned SUM_W   = 48;           // offset accumulator

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 10 * DW;
  localparam int unsigned OUT_TDATA_W = 7 * DW;   // 223 bits of fields, padded
  localparam int unsigned OUT_TUSER_W = 2;

  // Configuration register indexes
  localparam logic CFG_SENSOR_HEIGHT = 1'b0;
  localparam logic CFG_CALIB_LENGTH  = 1'b1;

  // Register reset values
  localparam logic [HW-1:0] SENSOR_HEIGHT_RST = HW'(2687);
  localparam logic [CW-1:0] CALIB_LENGTH_RST  = CW'(400);

  // One foot's readings
  typedef struct packed {
    logic signed [DW-1:0] fx;
    logic signed [DW-1:0] fy;
    logic signed [DW-1:0] fz;
    logic signed [DW-1:0] tx;
    logic signed [DW-1:0] ty;
  } foot_in_t;

  // One foot lane's findings
  typedef struct packed {
    logic signed [DW-1:0] zx;
    logic signed [DW-1:0] zy;
    logic signed [DW-1:0] fz;
    logic                 fault;
  } lane_res_t;

  // Final result of one beat
  typedef struct packed {
    logic                 fault;
    logic                 calibrated;
    logic        [DW-2:0] err;
    logic signed [DW-1:0] ry;
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ly;
    logic signed [DW-1:0] lx;
    logic signed [DW-1:0] zy;
    logic signed [DW-1:0] zx;
  } zmp_res_t;

  typedef enum logic [2:0] {
    L_IDLE, L_MUL, L_START, L_WAIT, L_DONE
  } lane_state_e;

  typedef enum logic [2:0] {
    M_IDLE, M_MUL, M_START, M_WAIT, M_ACC, M_OSTART, M_OWAIT, M_FIN
  } merge_state_e;

endpackage

[hw/rtl/zmp_estimator_offset_calibration_unit.sv]
// ----------------------------------------------------------------------------
// zmp_estimator_offset_calibration_unit
// ZMP estimator for a pair of ankle force/torque sensors with offset
// calibration of the combined x.
// ----------------------------------------------------------------------------
// One beat in gives one beat out, with one beat in flight at a time. The two
// foot lanes run side by side, each doing two divisions, then the merge stage
// does the two force-weighted combinations and, while the offset is being
// averaged (second sample up to the calibration length), the offset average,
// each a division on one shared bit-serial divider. A new beat is taken the
// cycle after the previous result has moved into the output register; a
// stalled output beat holds the finished result back and delays this.
module zmp_estimator_offset_calibration_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [zmpoc_pkg::HW-1:0]              cfg_data_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // left fx, fy, fz, tx, ty, right fx, fy, fz, tx, ty (32 bits each)
  input  logic [zmpoc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // zmp_x, zmp_y, left_zmp_x, left_zmp_y, right_zmp_x, right_zmp_y (32 each),
  // zmp_error (31), one pad bit
  output logic [zmpoc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // calibrated, divide_fault
  output logic [zmpoc_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);
  import zmpoc_pkg::*;

  logic [HW-1:0] height_q;
  logic [CW-1:0] calib_len_q;
  logic          busy_q;
  logic          tvalid_q;
  zmp_res_t      res_q;

  logic          in_fire;
  foot_in_t      left_in, right_in;
  logic          l_done, r_done;
  lane_res_t     l_res, r_res;
  logic          merge_start;
  logic          out_free;
  logic          res_valid;
  zmp_res_t      res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q    <= SENSOR_HEIGHT_RST;
      calib_len_q <= CALIB_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SENSOR_HEIGHT: height_q    <= cfg_data_i;
        CFG_CALIB_LENGTH:  calib_len_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // unpack input beat
  assign left_in.fx  = s_axis_tdata[0*DW +: DW];
  assign left_in.fy  = s_axis_tdata[1*DW +: DW];
  assign left_in.fz  = s_axis_tdata[2*DW +: DW];
  assign left_in.tx  = s_axis_tdata[3*DW +: DW];
  assign left_in.ty  = s_axis_tdata[4*DW +: DW];
  assign right_in.fx = s_axis_tdata[5*DW +: DW];
  assign right_in.fy = s_axis_tdata[6*DW +: DW];
  assign right_in.fz = s_axis_tdata[7*DW +: DW];
  assign right_in.tx = s_axis_tdata[8*DW +: DW];
  assign right_in.ty = s_axis_tdata[9*DW +: DW];

  assign s_axis_tready = !busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign merge_start   = l_done && r_done;
  assign out_free      = !tvalid_q || m_axis_tready;

  // one beat in flight; output register holds the last result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      tvalid_q <= 1'b0;
    end else begin
      if (in_fire)        busy_q <= 1'b1;
      else if (res_valid) busy_q <= 1'b0;
      if (res_valid)          tvalid_q <= 1'b1;
      else if (m_axis_tready) tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) res_q <= res;
  end

  zmpoc_foot_lane u_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .foot_i   (left_in),
    .height_i (height_q),
    .clear_i  (merge_start),
    .done_o   (l_done),
    .res_o    (l_res)
  );

  zmpoc_foot_lane u_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .foot_i   (right_in),
    .height_i (height_q),
    .clear_i  (merge_start),
    .done_o   (r_done),
    .res_o    (r_res)
  );

  zmpoc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (merge_start),
    .left_i      (l_res),
    .right_i     (r_res),
    .calib_len_i (calib_len_q),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = {1'b0, res_q.err, res_q.ry, res_q.rx, res_q.ly,
                          res_q.lx, res_q.zy, res_q.zx};
  assign m_axis_tuser  = {res_q.fault, res_q.calibrated};

endmodule

[hw/rtl/zmpoc_div.sv]
// ----------------------------------------------------------------------------
// zmpoc_div
// Signed restoring divider, one quotient bit per cycle. Truncates toward
// zero, saturates to the signed DW range, gives 0 and a fault on a zero divisor.
// ----------------------------------------------------------------------------
module zmpoc_div #(
  parameter int unsigned NUM_W = 50,
  parameter int unsigned DEN_W = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [NUM_W-1:0]       num_i,
  input  logic signed [DEN_W-1:0]       den_i,
  output logic                          done_o,
  output logic signed [zmpoc_pkg::DW-1:0] quot_o,
  output logic                          fault_o
);
  import zmpoc_pkg::*;

  localparam int unsigned CNTW = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNTW-1:0]  cnt_q;
  logic [NUM_W-1:0] nq_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic             neg_q;
  logic             zero_q;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;

  // one restoring step
  assign trial = {rem_q, nq_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q   <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      den_q  <= den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
      rem_q  <= '0;
      neg_q  <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq_q  <= {nq_q[NUM_W-2:0], ge};
    end
  end

  // sign and saturation
  always_comb begin
    if (zero_q) begin
      quot_o = '0;
    end else if (|nq_q[NUM_W-1:DW-1]) begin
      quot_o = neg_q ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else if (neg_q) begin
      quot_o = -$signed(nq_q[DW-1:0]);
    end else begin
      quot_o = $signed(nq_q[DW-1:0]);
    end
  end

  assign done_o  = done_q;
  assign fault_o = zero_q;

endmodule

[hw/rtl/zmpoc_foot_lane.sv]
// ----------------------------------------------------------------------------
// zmpoc_foot_lane
// ZMP of one foot: x = (-ty - h*fx)/fz, then y = (-tx - h*fy)/fz, on one
// multiplier and one iterative divider.
// ----------------------------------------------------------------------------
module zmpoc_foot_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  zmpoc_pkg::foot_in_t        foot_i,
  input  logic [zmpoc_pkg::HW-1:0]   height_i,
  input  logic                       clear_i,
  output logic                       done_o,
  output zmpoc_pkg::lane_res_t       res_o
);
  import zmpoc_pkg::*;

  lane_state_e state_q, state_d;

  foot_in_t                    foot_q;
  logic                        sel_y_q;
  logic signed [FOOT_NW-1:0]   prod_q;
  logic signed [FOOT_NW-1:0]   num;
  logic signed [FOOT_NW-1:0]   tq_ext;
  logic signed [DW-1:0]        force_sel;
  logic signed [DW-1:0]        torque_sel;
  logic signed [DW-1:0]        zx_q;
  logic signed [DW-1:0]        zy_q;
  logic                        fault_q;
  logic                        div_start;
  logic                        div_done;
  logic signed [DW-1:0]        div_quot;
  logic                        div_fault;

  assign force_sel  = sel_y_q ? foot_q.fy : foot_q.fx;
  assign torque_sel = sel_y_q ? foot_q.tx : foot_q.ty;

  // numerator: -(torque << FB) - h*force
  assign tq_ext = FOOT_NW'(torque_sel);
  assign num    = -(tq_ext <<< FB) - prod_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= L_IDLE;
    else         state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    case (state_q)
      L_IDLE:  if (start_i) state_d = L_MUL;
      L_MUL:   state_d = L_START;
      L_START: begin
        div_start = 1'b1;
        state_d   = L_WAIT;
      end
      L_WAIT:  if (div_done) state_d = sel_y_q ? L_DONE : L_MUL;
      L_DONE:  if (clear_i) state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: if (start_i) begin
        foot_q  <= foot_i;
        sel_y_q <= 1'b0;
        fault_q <= 1'b0;
      end
      L_MUL: prod_q <= FOOT_NW'($signed({1'b0, height_i}) * force_sel);
      L_WAIT: if (div_done) begin
        fault_q <= fault_q | div_fault;
        sel_y_q <= 1'b1;
        if (sel_y_q) zy_q <= div_quot;
        else         zx_q <= div_quot;
      end
      default: ;
    endcase
  end

  zmpoc_div #(
    .NUM_W(FOOT_NW),
    .DEN_W(DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (foot_q.fz),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .fault_o (div_fault)
  );

  assign done_o    = (state_q == L_DONE);
  assign res_o.zx    = zx_q;
  assign res_o.zy    = zy_q;
  assign res_o.fz    = foot_q.fz;
  assign res_o.fault = fault_q;

endmodule

[hw/rtl/zmpoc_merge.sv]
// ----------------------------------------------------------------------------
// zmpoc_merge
// Combines the two foot lanes weighted by vertical force, runs the offset
// calibration and applies the correction to the combined x.
// ----------------------------------------------------------------------------
module zmpoc_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  zmpoc_pkg::lane_res_t       left_i,
  input  zmpoc_pkg::lane_res_t       right_i,
  input  logic [zmpoc_pkg::CW-1:0]   calib_len_i,
  input  logic                       out_free_i,
  output logic                       res_valid_o,
  output zmpoc_pkg::zmp_res_t        res_o
);
  import zmpoc_pkg::*;

  merge_state_e state_q, state_d;

  lane_res_t                 l_q, r_q;
  logic                      sel_y_q;
  logic signed [2*DW-1:0]    prod_l_q, prod_r_q;
  logic signed [DW-1:0]      zx_q, zy_q;
  logic                      fault_q;
  logic [CW-1:0]             cnt_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic signed [DW-1:0]      ofs_q;

  logic                      div_start;
  logic                      div_done;
  logic signed [DW-1:0]      div_quot;
  logic                      div_fault;
  logic signed [MRG_NW-1:0]  div_num;
  logic signed [MRG_DW-1:0]  div_den;
  logic                      ofs_sel;
  logic                      acc_en;
  logic                      cal_en;
  logic signed [DW:0]        corr;
  logic signed [DW-1:0]      zx_out;
  logic signed [DW-1:0]      zx_abs;

  assign acc_en = (cnt_q != '0) && (cnt_q < calib_len_i);
  assign cal_en = (cnt_q >= calib_len_i);
  assign ofs_sel = (state_q == M_OSTART);

  // divider operands: weighted sum over total force, or offset average
  always_comb begin
    if (ofs_sel) begin
      div_num = MRG_NW'(sum_q);
      div_den = MRG_DW'({1'b0, cnt_q});
    end else begin
      div_num = MRG_NW'(prod_l_q) + MRG_NW'(prod_r_q);
      div_den = MRG_DW'(l_q.fz) + MRG_DW'(r_q.fz);
    end
  end

  // correction with saturation, then error magnitude
  assign corr = (DW+1)'(zx_q) - (DW+1)'(ofs_q);
  always_comb begin
    if (!cal_en)                          zx_out = zx_q;
    else if (corr > (DW+1)'(2**(DW-1)-1)) zx_out = {1'b0, {(DW-1){1'b1}}};
    else if (corr < -(DW+1)'(2**(DW-1)))  zx_out = {1'b1, {(DW-1){1'b0}}};
    else                                  zx_out = corr[DW-1:0];
    zx_abs = zx_out[DW-1] ? -zx_out : zx_out;
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= M_IDLE;
    else         state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d     = state_q;
    div_start   = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      M_IDLE:  if (start_i) state_d = M_MUL;
      M_MUL:   state_d = M_START;
      M_START: begin
        div_start = 1'b1;
        state_d   = M_WAIT;
      end
      M_WAIT:  if (div_done) state_d = sel_y_q ? M_ACC : M_MUL;
      M_ACC:   state_d = acc_en ? M_OSTART : M_FIN;
      M_OSTART: begin
        div_start = 1'b1;
        state_d   = M_OWAIT;
      end
      M_OWAIT: if (div_done) state_d = M_FIN;
      M_FIN: if (out_free_i) begin
        res_valid_o = 1'b1;
        state_d     = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
  end

  // calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      ofs_q <= '0;
    end else begin
      if (state_q == M_ACC && acc_en) sum_q <= sum_q + SUM_W'(zx_q);
      if (state_q == M_OWAIT && div_done) ofs_q <= div_quot;
      if (res_valid_o && !cal_en) cnt_q <= cnt_q + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: if (start_i) begin
        l_q     <= left_i;
        r_q     <= right_i;
        sel_y_q <= 1'b0;
        fault_q <= left_i.fault | right_i.fault;
      end
      M_MUL: begin
        prod_l_q <= (sel_y_q ? l_q.zy : l_q.zx) * l_q.fz;
        prod_r_q <= (sel_y_q ? r_q.zy : r_q.zx) * r_q.fz;
      end
      M_WAIT: if (div_done) begin
        fault_q <= fault_q | div_fault;
        sel_y_q <= 1'b1;
        if (sel_y_q) zy_q <= div_quot;
        else         zx_q <= div_quot;
      end
      default: ;
    endcase
  end

  zmpoc_div #(
    .NUM_W(MRG_NW),
    .DEN_W(MRG_DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .fault_o (div_fault)
  );

  assign res_o.zx         = zx_out;
  assign res_o.zy         = zy_q;
  assign res_o.lx         = l_q.zx;
  assign res_o.ly         = l_q.zy;
  assign res_o.rx         = r_q.zx;
  assign res_o.ry         = r_q.zy;
  assign res_o.err        = zx_abs[DW-1] ? {(DW-1){1'b1}} : zx_abs[DW-2:0];
  assign res_o.calibrated = cal_en;
  assign res_o.fault      = fault_q;

endmodule

[hw/rtl/zmpoc_checker.sv]
// ----------------------------------------------------------------------------
// zmpoc_checker
// Port-level checks for the ZMP estimator, bound to the top level.
// ----------------------------------------------------------------------------
module zmpoc_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [zmpoc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import zmpoc_pkg::*;

  // a held output beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // only one beat in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while busy");

  // no result right after one is taken
  a_no_back_to_back_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("result appeared without processing time");

  // error magnitude tracks a non-negative zmp_x
  a_err_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[DW-1] |->
      m_axis_tdata[6*DW +: DW-1] == m_axis_tdata[DW-2:0])
    else $error("zmp_error does not match zmp_x");

endmodule

bind zmp_estimator_offset_calibration_unit zmpoc_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[dv/zmp_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zmp_result_checker
// Watches the configuration port and both streams of the ZMP estimator,
// predicts each result from the accepted sensor beat and compares every
// output beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module zmp_result_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [zmpoc_pkg::HW-1:0]              cfg_data_i,
  input  logic                                  s_axis_tvalid,
  input  logic                                  s_axis_tready,
  input  logic [zmpoc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic [zmpoc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic [zmpoc_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
  output int                                    fail_cnt_o,
  output int                                    pending_o,
  output int                                    results_o,
  output int                                    corrected_o,
  output int                                    faults_o
);
  import zmpoc_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [DW-1:0] zx, zy, lx, ly, rx, ry;
    logic        [DW-2:0] err;
    logic                 cal;
    logic                 flt;
  } zmp_exp_t;

  zmp_exp_t          expected_zmp_q[$];
  logic [HW-1:0]     height_q;
  logic [CW-1:0]     calib_len_q;
  logic [CW-1:0]     sample_cnt_q;
  longint            offset_acc_q;
  longint            offset_avg_q;

  assign pending_o = expected_zmp_q.size();

  // saturate to the signed data range
  function automatic logic signed [DW-1:0] clamp_dw(wide_t v);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (DW - 1)) - 1;
    lo = -(wide_t'(1) <<< (DW - 1));
    if (v > hi) return hi[DW-1:0];
    if (v < lo) return lo[DW-1:0];
    return v[DW-1:0];
  endfunction

  // (-torque - h * force) / fz, one foot
  function automatic logic signed [DW-1:0] foot_point(logic signed [DW-1:0] torque,
      logic signed [DW-1:0] force_v, logic signed [DW-1:0] fz, inout logic flt);
    wide_t t, f, d, h, num;
    t = torque;
    f = force_v;
    d = fz;
    h = $signed({{(128-HW){1'b0}}, height_q});
    num = -(t <<< FB) - h * f;
    if (d == 0) begin
      flt = 1'b1;
      return '0;
    end
    return clamp_dw(num / d);
  endfunction

  // force weighted merge of both feet
  function automatic logic signed [DW-1:0] weigh_feet(logic signed [DW-1:0] zl,
      logic signed [DW-1:0] fl, logic signed [DW-1:0] zr, logic signed [DW-1:0] fr,
      inout logic flt);
    wide_t a, b, c, e, num, d;
    a = zl;
    b = fl;
    c = zr;
    e = fr;
    num = a * b + c * e;
    d = b + e;
    if (d == 0) begin
      flt = 1'b1;
      return '0;
    end
    return clamp_dw(num / d);
  endfunction

  // predict one result and advance the calibration state
  task automatic predict_zmp(input logic [IN_TDATA_W-1:0] beat);
    zmp_exp_t             r;
    logic signed [DW-1:0] f[10];
    wide_t                zx_w, mag;
    for (int i = 0; i < 10; i++) f[i] = beat[i*DW +: DW];
    r.flt = 1'b0;
    r.cal = 1'b0;
    r.lx = foot_point(f[4], f[0], f[2], r.flt);
    r.rx = foot_point(f[9], f[5], f[7], r.flt);
    r.ly = foot_point(f[3], f[1], f[2], r.flt);
    r.ry = foot_point(f[8], f[6], f[7], r.flt);
    r.zx = weigh_feet(r.lx, f[2], r.rx, f[7], r.flt);
    r.zy = weigh_feet(r.ly, f[2], r.ry, f[7], r.flt);
    // running offset average during calibration
    if (sample_cnt_q >= 1 && sample_cnt_q < calib_len_q) begin
      offset_acc_q = offset_acc_q + longint'(r.zx);
      offset_avg_q = offset_acc_q / longint'({48'b0, sample_cnt_q});
    end
    if (sample_cnt_q >= calib_len_q) begin
      zx_w = wide_t'(r.zx) - wide_t'(offset_avg_q);
      r.zx = clamp_dw(zx_w);
      r.cal = 1'b1;
    end else begin
      sample_cnt_q = sample_cnt_q + 1'b1;
    end
    mag = r.zx;
    if (mag < 0) mag = -mag;
    if (mag > (wide_t'(1) <<< (DW - 1)) - 1) mag = (wide_t'(1) <<< (DW - 1)) - 1;
    r.err = mag[DW-2:0];
    expected_zmp_q.insert(expected_zmp_q.size(), r);
  endtask

  task automatic report(string name, logic [DW-1:0] exp_v, logic [DW-1:0] act_v);
    fail_cnt_o++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
  endtask

  // sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    zmp_exp_t e;
    if (!rst_ni) begin
      height_q     = SENSOR_HEIGHT_RST;
      calib_len_q  = CALIB_LENGTH_RST;
      sample_cnt_q = '0;
      offset_acc_q = 0;
      offset_avg_q = 0;
      fail_cnt_o   = 0;
      results_o    = 0;
      corrected_o  = 0;
      faults_o     = 0;
      expected_zmp_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SENSOR_HEIGHT) height_q = cfg_data_i;
        else calib_len_q = cfg_data_i[CW-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_zmp_q.size() == 0) begin
          fail_cnt_o++;
          $display("%0t: unexpected result beat, expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          e = expected_zmp_q.pop_front();
          results_o++;
          if (e.cal) corrected_o++;
          if (e.flt) faults_o++;
          if (m_axis_tdata[0*DW +: DW] !== e.zx)
            report("zmp_x", e.zx, m_axis_tdata[0*DW +: DW]);
          if (m_axis_tdata[1*DW +: DW] !== e.zy)
            report("zmp_y", e.zy, m_axis_tdata[1*DW +: DW]);
          if (m_axis_tdata[2*DW +: DW] !== e.lx)
            report("left_zmp_x", e.lx, m_axis_tdata[2*DW +: DW]);
          if (m_axis_tdata[3*DW +: DW] !== e.ly)
            report("left_zmp_y", e.ly, m_axis_tdata[3*DW +: DW]);
          if (m_axis_tdata[4*DW +: DW] !== e.rx)
            report("right_zmp_x", e.rx, m_axis_tdata[4*DW +: DW]);
          if (m_axis_tdata[5*DW +: DW] !== e.ry)
            report("right_zmp_y", e.ry, m_axis_tdata[5*DW +: DW]);
          if (m_axis_tdata[6*DW +: DW-1] !== e.err)
            report("zmp_error", {1'b0, e.err}, {1'b0, m_axis_tdata[6*DW +: DW-1]});
          if (m_axis_tuser[0] !== e.cal) report("calibrated", e.cal, m_axis_tuser[0]);
          if (m_axis_tuser[1] !== e.flt) report("divide_fault", e.flt, m_axis_tuser[1]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_zmp(s_axis_tdata);
    end
  end

endmodule

[dv/tb_zmp_estimator_offset_calibration_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zmp_estimator_offset_calibration_unit
// Drives sensor beats into the ZMP estimator through several height and
// calibration length settings, with random gaps on both streams; a checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_zmp_estimator_offset_calibration_unit;
  import zmpoc_pkg::*;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic                    cfg_idx_i;
  logic [HW-1:0]           cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic [OUT_TUSER_W-1:0]  m_axis_tuser;

  int fail_cnt, pending, results, corrected, faults;
  int beats_sent;
  bit stall_on;

  zmp_estimator_offset_calibration_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  zmp_result_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .results_o(results),
    .corrected_o(corrected), .faults_o(faults)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // gap length: mostly short, a few long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // random receiver stalls
  always @(negedge clk_i) begin
    int stall_left;
    if (!stall_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = gap_len();
    end
  end

  // one signed Q16.16 field of a chosen flavor
  function automatic logic [31:0] pick_field(int scale);
    int p;
    p = $urandom_range(0, 99);
    if (p < 15) return $urandom;
    if (p < 20) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        3: return 32'hffff_ffff;
        default: return 32'h0000_0001;
      endcase
    end
    return 32'($signed($urandom_range(0, 2 * scale)) - scale) <<< 16;
  endfunction

  // vertical force pair, mostly realistic stance loads
  function automatic void pick_vertical(output logic [31:0] lz, output logic [31:0] rz);
    int p;
    p = $urandom_range(0, 99);
    lz = 32'($urandom_range(20, 700)) <<< 16 | 32'($urandom_range(0, 65535));
    rz = 32'($urandom_range(20, 700)) <<< 16 | 32'($urandom_range(0, 65535));
    if (p < 5) lz = '0;
    else if (p < 10) rz = '0;
    else if (p < 14) rz = -lz;
    else if (p < 22) begin
      lz = $urandom;
      rz = $urandom;
    end else if (p < 26) lz = 32'($urandom_range(1, 3));
  endfunction

  function automatic logic [IN_TDATA_W-1:0] random_beat();
    logic [31:0] f[10];
    logic [IN_TDATA_W-1:0] b;
    for (int i = 0; i < 10; i++) f[i] = pick_field((i % 5) < 2 ? 60 : 25);
    pick_vertical(f[2], f[7]);
    for (int i = 0; i < 10; i++) b[i*32 +: 32] = f[i];
    return b;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_beat(logic [31:0] lfx, logic [31:0] lfy,
      logic [31:0] lfz, logic [31:0] ltx, logic [31:0] lty, logic [31:0] rfx,
      logic [31:0] rfy, logic [31:0] rfz, logic [31:0] rtx, logic [31:0] rty);
    return {rty, rtx, rfz, rfy, rfx, lty, ltx, lfz, lfy, lfx};
  endfunction

  // offer one sensor beat and wait for it to be taken; tready only moves at
  // the rising edge, so its value at the falling edge tells the next edge
  task automatic send_beat(input logic [IN_TDATA_W-1:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    while (!s_axis_tready) @(negedge clk_i);
    @(negedge clk_i);
    beats_sent++;
  endtask

  task automatic drain_and_write(input logic idx, input logic [HW-1:0] val);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic random_run(input int n);
    repeat (n) send_beat(random_beat());
  endtask

  localparam logic [31:0] MAXP = 32'h7fff_ffff;
  localparam logic [31:0] MINN = 32'h8000_0000;
  localparam logic [31:0] N300 = 32'd300 <<< 16;
  localparam logic [31:0] ONE  = 32'd1 <<< 16;

  initial begin
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_SENSOR_HEIGHT;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    stall_on      = 1'b0;
    beats_sent    = 0;
    rst_ni        = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed beats at reset settings; first sample neither sums nor corrects
    send_beat(pack_beat(ONE, -ONE, N300, ONE, -ONE, ONE, ONE, N300, -ONE, ONE));
    send_beat('0);
    send_beat({10{MAXP}});
    send_beat({10{MINN}});
    send_beat(pack_beat(MAXP, MINN, 32'd1, MINN, MAXP, MINN, MAXP, 32'd1, MAXP, MINN));
    send_beat(pack_beat(ONE, ONE, '0, ONE, ONE, ONE, ONE, N300, ONE, ONE));
    send_beat(pack_beat(ONE, ONE, N300, ONE, ONE, ONE, ONE, '0, ONE, ONE));
    send_beat(pack_beat(ONE, ONE, N300, ONE, ONE, ONE, ONE, -N300, ONE, ONE));
    send_beat(pack_beat(MINN, MINN, -32'd1, MINN, MINN, MAXP, MAXP, 32'd1, MAXP, MAXP));
    send_beat(pack_beat(MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP));
    send_beat(pack_beat(MINN, MINN, MINN, MINN, MINN, MINN, MINN, MAXP, MINN, MINN));
    send_beat(pack_beat(32'hffff_ffff, '0, 32'hffff_ffff, 32'hffff_ffff, '0,
                        '0, 32'hffff_ffff, 32'd1, '0, 32'hffff_ffff));
    send_beat(pack_beat('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    stall_on = 1'b1;
    random_run(400);

    // tallest sensor, longest calibration: summing resumes past the old length
    drain_and_write(CFG_SENSOR_HEIGHT, 17'd65536);
    drain_and_write(CFG_CALIB_LENGTH, 17'd65535);
    random_run(300);

    // no height, calibration length lowered below the count
    drain_and_write(CFG_SENSOR_HEIGHT, 17'd0);
    drain_and_write(CFG_CALIB_LENGTH, 17'd2);
    send_beat({10{MAXP}});
    send_beat({10{MINN}});
    random_run(300);

    // mid settings, then back to the default height
    drain_and_write(CFG_SENSOR_HEIGHT, 17'($urandom_range(1, 65535)));
    drain_and_write(CFG_CALIB_LENGTH, 17'd1200);
    random_run(300);
    drain_and_write(CFG_SENSOR_HEIGHT, SENSOR_HEIGHT_RST);
    drain_and_write(CFG_CALIB_LENGTH, 17'd3);
    random_run(330);

    // wait for the last results, then a short settle
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);

    $display("Sent %0d sensor beats over five height/calibration settings.", beats_sent);
    $display("Checked %0d results: %0d offset corrected, %0d with a zero divisor.",
             results, corrected, faults);
    if (fail_cnt == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #60ms;
    $display("Timeout with %0d results outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
